@@ hdl/mjs_pkg.sv @@
// Package for the feedback-queue job scheduler: sizes, codes and helpers.
// No dependencies; used by every module in hdl.
package mjs_pkg;
	localparam int MaxJobs = 16;
	localparam int Levels = 3;
	localparam int SlotW = $clog2(MaxJobs);
	localparam int CntW = $clog2(MaxJobs + 1);
	localparam int LvW = $clog2(Levels);
	localparam int QDepth = Levels * MaxJobs;
	localparam int QAddrW = $clog2(QDepth);
	localparam logic [19:0] Max20 = 20'hFFFFF;

	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_ENQ = 3'd1;
	localparam logic [2:0] MODE_DEQ = 3'd2;
	localparam logic [2:0] MODE_STAT = 3'd3;
	localparam logic [2:0] MODE_DONE = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam logic [1:0] ACT_KEEP = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_SWITCH = 2'd2;
	localparam logic [1:0] ACT_IDLE = 2'd3;

	localparam logic [2:0] REG_TICK = 3'd0;
	localparam logic [2:0] REG_PROMOTE = 3'd1;
	localparam logic [2:0] REG_SLICE0 = 3'd2;
	localparam logic [2:0] REG_SLICE1 = 3'd3;
	localparam logic [2:0] REG_SLICE2 = 3'd4;

	// Level of a priority: priority minus one, clamped to the level range.
	function automatic logic [LvW-1:0] level_of(input logic [1:0] p);
		logic [1:0] l;
		l = (p > 2'd0) ? p - 2'd1 : 2'd0;
		if (l > 2'(Levels - 1)) l = 2'(Levels - 1);
		return l[LvW-1:0];
	endfunction

	// Saturating adds used for the wait, slice and run counters.
	function automatic logic [19:0] sat20(input logic [19:0] a, input logic [15:0] b);
		logic [20:0] s;
		s = {1'b0, a} + {5'd0, b};
		return s[20] ? Max20 : s[19:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

	typedef struct packed {
		logic        kind;
		logic [15:0] jid;
		logic [15:0] owner_id;
		logic [31:0] run_total;
		logic [19:0] wait_total;
		logic [1:0]  cur_priority;
		logic        is_running;
		logic [1:0]  status;
		logic [1:0]  action;
		logic [15:0] new_jid;
		logic [15:0] stopped_jid;
		logic        last;
	} result_t;
endpackage

@@ hdl/mjs_out_reg.sv @@
// Output register of the scheduler: holds one result until the sink takes it.
// Depends on mjs_pkg for the result record type.
module mjs_out_reg import mjs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	output logic    full,
	input  logic    take,
	output result_t dout
);
	logic full_q;
	result_t data_q;

	// A result is loaded only when the register is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= din;
	end

	assign full = full_q;
	assign dout = data_q;
endmodule

@@ hdl/mlfq_job_scheduler.sv @@
// Top level of the feedback-queue job scheduler: sequencer, job table and queues.
// Depends on mjs_pkg and mjs_out_reg.
//
// Usage: items enter on the s_axis channel; tdata packs mode, priority_req,
// owner and target_jid. Every mode other than "job done" is a scheduler tick
// that yields zero or more stat records (mode 3) followed by one schedule report
// with tlast high. Results leave on m_axis through a one-entry output register;
// tuser carries kind. Configuration is written on cfg_we/cfg_idx/cfg_wdata.
// One sequencer walks the three level queues one entry per cycle, except while
// a stat record waits for the output register; the job table is read at the
// slot of each queue entry. s_axis_tready is low while an item is at work.
// When the receiver stalls, the sequencer waits at the output register without
// losing a result. Reset empties the table and queues (valid bits and counts
// cleared at once) and restores register defaults.
module mlfq_job_scheduler import mjs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[2:0], priority_req[4:3], owner[20:5], target_jid[36:21], zero fill
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// jid, owner_id, run_total, wait_total, cur_priority, is_running,
	// status, action, new_jid, stopped_jid from bit 0 up, zero fill
	output logic [127:0] m_axis_tdata,
	// kind
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [19:0] cfg_wdata
);
	typedef enum logic [3:0] {
		S_IDLE, S_CMD, S_DEQ, S_STATR, S_STATQ, S_AGE, S_MOVE, S_SEL,
		S_REM, S_SWITCH, S_REPORT
	} state_t;

	// Configuration registers.
	logic [15:0] tick_q;
	logic [19:0] promote_q;
	logic [19:0] slice_q [Levels];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 16'd500;
			promote_q <= 20'd10000;
			slice_q[0] <= 20'd5000;
			slice_q[1] <= 20'd2000;
			slice_q[2] <= 20'd1000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TICK:    tick_q <= cfg_wdata[15:0];
				REG_PROMOTE: promote_q <= cfg_wdata;
				REG_SLICE0:  slice_q[0] <= cfg_wdata;
				REG_SLICE1:  slice_q[1] <= cfg_wdata;
				REG_SLICE2:  slice_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Job table: slot fields are small registers read at the sequencer's slot.
	logic [MaxJobs-1:0] valid_q;
	logic [15:0] jid_q [MaxJobs];
	logic [15:0] own_q [MaxJobs];
	logic [1:0]  defp_q [MaxJobs];
	logic [1:0]  curp_q [MaxJobs];
	logic [19:0] wait_q [MaxJobs];
	logic [19:0] slc_q [MaxJobs];
	logic [31:0] run_q [MaxJobs];

	// Level queues share one memory; entry (level, pos) at level*MaxJobs+pos.
	logic [SlotW-1:0] qmem [QDepth];
	logic [SlotW-1:0] qrd_q;
	logic [CntW-1:0] cnt_q [Levels];

	state_t state_q;
	logic [2:0]  mode_q;
	logic [1:0]  prq_q;
	logic [15:0] owner_q, target_q;
	logic [1:0]  status_q;
	logic [15:0] newj_q, stop_q;
	logic [15:0] jctr_q;
	logic [SlotW-1:0] rs_q;
	logic rv_q, rd_q;
	logic [LvW-1:0] lv_q;
	logic [CntW-1:0] pos_q, wr_q;
	logic rdv_q;
	logic found_q, hasn_q;
	logic [2:0] high_q;
	logic [LvW-1:0] low_q, bl_q;
	logic [CntW-1:0] bp_q;
	logic [SlotW-1:0] bs_q;
	logic [1:0] act_q;

	logic or_full, or_load;
	result_t or_din, or_dout;

	mjs_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .load(or_load), .din(or_din),
		.full(or_full), .take(m_axis_tready), .dout(or_dout)
	);

	logic out_free;
	assign out_free = !or_full || m_axis_tready;

	// Queue read address follows the sequencer's level and position.
	logic [QAddrW-1:0] raddr;
	always_comb begin
		raddr = QAddrW'(lv_q) * QAddrW'(MaxJobs) + QAddrW'(pos_q);
	end

	// Free-slot search over the valid bits (priority encoder).
	logic [SlotW-1:0] free_s;
	logic free_ok;
	always_comb begin
		free_s = '0;
		free_ok = 1'b0;
		for (int i = MaxJobs - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_s = SlotW'(i);
				free_ok = 1'b1;
			end
		end
	end

	// Next job id; zero is skipped when the counter wraps.
	logic [15:0] nj;
	assign nj = (jctr_q == 16'hFFFF) ? 16'd1 : jctr_q + 16'd1;

	// Record builder for one slot.
	function automatic result_t rec(input logic k, input logic has,
			input logic [15:0] j, input logic [15:0] o, input logic [31:0] r,
			input logic [19:0] w, input logic [1:0] p, input logic isr);
		result_t x;
		x = '0;
		x.kind = k;
		if (has) begin
			x.jid = j; x.owner_id = o; x.run_total = r;
			x.wait_total = w; x.cur_priority = p; x.is_running = isr;
		end
		return x;
	endfunction

	logic [SlotW-1:0] qs;
	assign qs = qrd_q;
	logic [19:0] aged_w;
	assign aged_w = sat20(wait_q[qs], tick_q);
	logic [LvW-1:0] tgt_lv;
	assign tgt_lv = level_of(curp_q[qs]);
	logic [1:0] demote;
	always_comb begin
		demote = (curp_q[rs_q] > 2'd0) ? curp_q[rs_q] - 2'd1 : 2'd0;
		if (demote < defp_q[rs_q]) demote = defp_q[rs_q];
	end

	assign s_axis_tready = (state_q == S_IDLE);

	// Queue memory: read registered, one write a cycle. The read data holds
	// its entry while a stat record waits for the output register.
	logic qwe;
	logic [QAddrW-1:0] qwa;
	logic [SlotW-1:0] qwd;
	logic qre;
	assign qre = !(state_q == S_STATQ && rdv_q && !out_free);
	always_ff @(posedge clk) begin
		if (qwe) qmem[qwa] <= qwd;
		if (qre) qrd_q <= qmem[raddr];
	end

	always_comb begin
		qwe = 1'b0;
		qwa = raddr;
		qwd = qrd_q;
		or_load = 1'b0;
		or_din = '0;
		unique case (state_q)
			S_CMD: begin
				if (mode_q == MODE_ENQ && free_ok) begin
					qwe = 1'b1;
					qwa = QAddrW'(cnt_q[0]);
					qwd = free_s;
				end
			end
			S_DEQ, S_REM: begin
				// Compaction: entry at pos-1 gets the entry at pos.
				if (rdv_q && found_q) begin
					qwe = 1'b1;
					qwa = QAddrW'(lv_q) * QAddrW'(MaxJobs) + QAddrW'(wr_q);
				end
			end
			S_MOVE: begin
				if (rdv_q) begin
					qwe = 1'b1;
					if (tgt_lv > lv_q) begin
						qwa = QAddrW'(tgt_lv) * QAddrW'(MaxJobs) + QAddrW'(cnt_q[tgt_lv]);
					end else begin
						qwa = QAddrW'(lv_q) * QAddrW'(MaxJobs) + QAddrW'(wr_q);
					end
				end
			end
			S_SWITCH: begin
				if (rv_q && !rd_q && hasn_q) begin
					qwe = 1'b1;
					qwa = QAddrW'(level_of(demote)) * QAddrW'(MaxJobs)
						+ QAddrW'(cnt_q[level_of(demote)]);
					qwd = rs_q;
				end
			end
			S_STATR: begin
				or_load = rv_q && out_free;
				or_din = rec(1'b1, 1'b1, jid_q[rs_q], own_q[rs_q], run_q[rs_q],
					wait_q[rs_q], curp_q[rs_q], 1'b1);
			end
			S_STATQ: begin
				or_load = rdv_q && out_free;
				or_din = rec(1'b1, 1'b1, jid_q[qs], own_q[qs], run_q[qs],
					wait_q[qs], curp_q[qs], 1'b0);
			end
			S_REPORT: begin
				or_load = out_free;
				or_din = rec(1'b0, rv_q, jid_q[rs_q], own_q[rs_q], run_q[rs_q],
					wait_q[rs_q], curp_q[rs_q], 1'b1);
				or_din.status = status_q;
				or_din.action = act_q;
				or_din.new_jid = newj_q;
				or_din.stopped_jid = stop_q;
				or_din.last = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer. Queue walks use pos_q as read pointer; rdv_q marks that
	// qrd_q holds the entry at pos_q-1, and wr_q is the compaction pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			for (int l = 0; l < Levels; l++) cnt_q[l] <= '0;
			rs_q <= '0; rv_q <= 1'b0; rd_q <= 1'b0; jctr_q <= '0;
			lv_q <= '0; pos_q <= '0; wr_q <= '0; rdv_q <= 1'b0;
			found_q <= 1'b0; hasn_q <= 1'b0; high_q <= '0; low_q <= '0;
			bl_q <= '0; bp_q <= '0; bs_q <= '0; act_q <= ACT_IDLE;
			mode_q <= '0; prq_q <= '0; owner_q <= '0; target_q <= '0;
			status_q <= ST_OK; newj_q <= '0; stop_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q <= s_axis_tdata[2:0];
						prq_q <= s_axis_tdata[4:3];
						owner_q <= s_axis_tdata[20:5];
						target_q <= s_axis_tdata[36:21];
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					status_q <= ST_OK; newj_q <= '0; stop_q <= '0;
					lv_q <= LvW'(Levels - 1); pos_q <= '0; wr_q <= '0;
					rdv_q <= 1'b0; found_q <= 1'b0;
					state_q <= S_AGE;
					unique case (mode_q)
						MODE_DONE: begin
							if (rv_q) rd_q <= 1'b1;
							state_q <= S_IDLE;
						end
						MODE_ENQ: begin
							if (!free_ok) begin
								status_q <= ST_FULL;
							end else begin
								jctr_q <= nj;
								newj_q <= nj;
								valid_q[free_s] <= 1'b1;
								jid_q[free_s] <= nj; own_q[free_s] <= owner_q;
								defp_q[free_s] <= prq_q; curp_q[free_s] <= prq_q;
								wait_q[free_s] <= '0; slc_q[free_s] <= '0;
								run_q[free_s] <= '0;
								cnt_q[0] <= cnt_q[0] + 1'b1;
							end
							lv_q <= '0;
						end
						MODE_DEQ: begin
							if (rv_q && jid_q[rs_q] == target_q) begin
								valid_q[rs_q] <= 1'b0;
								rv_q <= 1'b0; rd_q <= 1'b0;
								stop_q <= target_q;
								lv_q <= '0;
							end else begin
								state_q <= S_DEQ;
							end
						end
						MODE_STAT: state_q <= S_STATR;
						default: lv_q <= '0;
					endcase
				end
				S_DEQ: begin
					// Search from the highest level; remove by shifting down.
					if (rdv_q) begin
						if (found_q) begin
							wr_q <= wr_q + 1'b1;
						end else if (jid_q[qs] == target_q) begin
							found_q <= 1'b1;
							valid_q[qs] <= 1'b0;
							wr_q <= pos_q - 1'b1;
						end
					end
					if (pos_q < cnt_q[lv_q]) begin
						pos_q <= pos_q + 1'b1;
						rdv_q <= 1'b1;
					end else if (rdv_q) begin
						rdv_q <= 1'b0;
					end else begin
						if (found_q) cnt_q[lv_q] <= cnt_q[lv_q] - 1'b1;
						pos_q <= '0; wr_q <= '0;
						if (found_q || lv_q == '0) begin
							if (!found_q) status_q <= ST_NOTFOUND;
							found_q <= 1'b0;
							lv_q <= '0;
							state_q <= S_AGE;
						end else begin
							lv_q <= lv_q - 1'b1;
						end
					end
				end
				S_STATR: begin
					if (!rv_q || out_free) state_q <= S_STATQ;
				end
				S_STATQ: begin
					if (!rdv_q || out_free) begin
						if (pos_q < cnt_q[lv_q]) begin
							pos_q <= pos_q + 1'b1;
							rdv_q <= 1'b1;
						end else if (rdv_q) begin
							rdv_q <= 1'b0;
						end else begin
							pos_q <= '0;
							if (lv_q == '0) state_q <= S_AGE;
							else lv_q <= lv_q - 1'b1;
						end
					end
				end
				S_AGE: begin
					// Running job's counters first, then every queued job.
					if (pos_q == '0 && !rdv_q && lv_q == '0 && rv_q && !found_q) begin
						run_q[rs_q] <= sat32(run_q[rs_q], tick_q);
						slc_q[rs_q] <= sat20(slc_q[rs_q], tick_q);
						found_q <= 1'b1;
					end
					if (rdv_q) begin
						if (aged_w >= promote_q && curp_q[qs] < 2'(Levels)) begin
							curp_q[qs] <= curp_q[qs] + 2'd1;
							wait_q[qs] <= '0;
						end else begin
							wait_q[qs] <= aged_w;
						end
					end
					if (pos_q < cnt_q[lv_q]) begin
						pos_q <= pos_q + 1'b1;
						rdv_q <= 1'b1;
					end else if (rdv_q) begin
						rdv_q <= 1'b0;
					end else begin
						pos_q <= '0;
						if (lv_q == LvW'(Levels - 1)) begin
							lv_q <= '0; wr_q <= '0; found_q <= 1'b0;
							state_q <= S_MOVE;
						end else begin
							lv_q <= lv_q + 1'b1;
						end
					end
				end
				S_MOVE: begin
					// Jobs whose level rose leave for the tail of a higher queue.
					if (rdv_q) begin
						if (tgt_lv > lv_q) cnt_q[tgt_lv] <= cnt_q[tgt_lv] + 1'b1;
						else wr_q <= wr_q + 1'b1;
					end
					if (pos_q < cnt_q[lv_q]) begin
						pos_q <= pos_q + 1'b1;
						rdv_q <= 1'b1;
					end else if (rdv_q) begin
						rdv_q <= 1'b0;
					end else begin
						cnt_q[lv_q] <= wr_q;
						pos_q <= '0; wr_q <= '0;
						if (lv_q == LvW'(Levels - 1)) begin
							hasn_q <= 1'b0;
							high_q <= 3'b111;
							low_q <= '0;
							if (rv_q) begin
								low_q <= level_of(curp_q[rs_q]);
								if (slc_q[rs_q] < slice_q[level_of(curp_q[rs_q])])
									high_q <= {1'b0, curp_q[rs_q]};
							end
							state_q <= S_SEL;
						end else begin
							lv_q <= lv_q + 1'b1;
						end
					end
				end
				S_SEL: begin
					// high_q of all ones stands for "no bound".
					if (rdv_q) begin
						if (high_q == 3'b111 || {1'b0, curp_q[qs]} > high_q) begin
							high_q <= {1'b0, curp_q[qs]};
							hasn_q <= 1'b1;
							bl_q <= lv_q; bp_q <= pos_q - 1'b1; bs_q <= qs;
						end
					end
					if (pos_q < cnt_q[lv_q]) begin
						pos_q <= pos_q + 1'b1;
						rdv_q <= 1'b1;
					end else if (rdv_q) begin
						rdv_q <= 1'b0;
					end else begin
						pos_q <= '0;
						if (hasn_q) begin
							lv_q <= bl_q;
							pos_q <= bp_q + 1'b1;
							wr_q <= bp_q;
							found_q <= 1'b1;
							state_q <= S_REM;
						end else if (lv_q == low_q) begin
							state_q <= S_SWITCH;
						end else begin
							lv_q <= lv_q - 1'b1;
						end
					end
				end
				S_REM: begin
					if (rdv_q) wr_q <= wr_q + 1'b1;
					if (pos_q < cnt_q[lv_q]) begin
						pos_q <= pos_q + 1'b1;
						rdv_q <= 1'b1;
					end else if (rdv_q) begin
						rdv_q <= 1'b0;
					end else begin
						cnt_q[lv_q] <= cnt_q[lv_q] - 1'b1;
						found_q <= 1'b0;
						state_q <= S_SWITCH;
					end
				end
				S_SWITCH: begin
					if (rv_q && rd_q) begin
						valid_q[rs_q] <= 1'b0;
					end
					if (!hasn_q && (!rv_q || rd_q)) begin
						act_q <= ACT_IDLE;
						rv_q <= 1'b0; rd_q <= 1'b0;
					end else if (hasn_q && (!rv_q || rd_q)) begin
						rs_q <= bs_q; rv_q <= 1'b1; rd_q <= 1'b0;
						slc_q[bs_q] <= '0;
						act_q <= ACT_START;
					end else if (hasn_q) begin
						curp_q[rs_q] <= demote;
						wait_q[rs_q] <= '0;
						cnt_q[level_of(demote)] <= cnt_q[level_of(demote)] + 1'b1;
						stop_q <= jid_q[rs_q];
						rs_q <= bs_q; rd_q <= 1'b0;
						slc_q[bs_q] <= '0;
						wait_q[bs_q] <= '0;
						act_q <= ACT_SWITCH;
					end else begin
						act_q <= ACT_KEEP;
					end
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (out_free) begin
						lv_q <= '0; pos_q <= '0; rdv_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = or_full;
	assign m_axis_tuser = or_dout.kind;
	assign m_axis_tlast = or_dout.last;
	assign m_axis_tdata = {5'b0, or_dout.stopped_jid, or_dout.new_jid, or_dout.action,
		or_dout.status, or_dout.is_running, or_dout.cur_priority, or_dout.wait_total,
		or_dout.run_total, or_dout.owner_id, or_dout.jid};

	// Queue counts never exceed the table size.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CntW'(MaxJobs) && cnt_q[1] <= CntW'(MaxJobs)
		&& cnt_q[2] <= CntW'(MaxJobs))
		else $error("queue count above table size");
	// A done flag only stands with a running job.
	a_done: assert property (@(posedge clk) disable iff (!arst_n) rd_q |-> rv_q)
		else $error("done flag without running job");
	// No item is accepted while a result is being sequenced.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		or_load |-> !s_axis_tready)
		else $error("result produced while idle");
	// A running job owns a valid slot whenever the sequencer is idle.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && rv_q) |-> valid_q[rs_q])
		else $error("running job in a free slot");
endmodule

@@ tb/mlfq_checker.sv @@
// Result checker for the feedback-queue job scheduler: watches all channels,
// predicts every result and compares it. Depends on mjs_pkg.
`timescale 1ns / 1ps
module mlfq_checker import mjs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [19:0]  cfg_wdata,
	output int           pending,
	output int           errors
);
	// Shadow copy of the scheduler's configuration and job table.
	logic [15:0] tick_len;
	logic [19:0] promote_lim;
	logic [19:0] slice_len [Levels];
	logic        job_valid [MaxJobs];
	logic [15:0] job_id [MaxJobs];
	logic [15:0] job_owner [MaxJobs];
	logic [1:0]  job_dflt [MaxJobs];
	logic [1:0]  job_pri [MaxJobs];
	logic [19:0] job_wait [MaxJobs];
	logic [19:0] job_slice [MaxJobs];
	logic [31:0] job_run [MaxJobs];
	int          waitq [Levels][$];
	int          run_slot;
	logic        run_valid, run_done;
	logic [15:0] id_count;
	result_t     sched_results [$];

	assign pending = sched_results.size();

	function automatic int lvl(input logic [1:0] p);
		int l;
		l = (p > 0) ? p - 1 : 0;
		return (l > Levels - 1) ? Levels - 1 : l;
	endfunction

	function automatic result_t job_record(input logic kind, input logic has, input int s);
		result_t r;
		r = '0;
		r.kind = kind;
		if (has) begin
			r.jid = job_id[s];
			r.owner_id = job_owner[s];
			r.run_total = job_run[s];
			r.wait_total = job_wait[s];
			r.cur_priority = job_pri[s];
			r.is_running = 1'b1;
		end
		return r;
	endfunction

	// Append an expected result at the tail of the list.
	task automatic add_expected(input result_t r);
		sched_results = {sched_results, r};
	endtask

	// Append a slot at the tail of a level's waiting list.
	task automatic add_waiting(input int l, input int s);
		waitq[l] = {waitq[l], s};
	endtask

	// Apply one input item and queue the results it causes.
	task automatic schedule_step(input logic [39:0] d);
		logic [2:0]  mode;
		logic [1:0]  preq;
		logic [15:0] own, tgt;
		logic [1:0]  st, act;
		logic [15:0] nid, stopped;
		logic        found, has_next;
		int          s, next_slot, highest, lowest, best, t, pos, c;
		result_t     r;
		mode = d[2:0];
		preq = d[4:3];
		own = d[20:5];
		tgt = d[36:21];
		st = ST_OK;
		nid = '0;
		stopped = '0;
		has_next = 1'b0;
		next_slot = 0;
		if (mode == MODE_DONE) begin
			if (run_valid) run_done = 1'b1;
			return;
		end
		// Command part of the tick.
		if (mode == MODE_ENQ) begin
			s = 0;
			while (s < MaxJobs && job_valid[s]) s++;
			if (s >= MaxJobs) begin
				st = ST_FULL;
			end else begin
				id_count++;
				if (id_count == 0) id_count = 1;
				job_valid[s] = 1'b1;
				job_id[s] = id_count;
				job_owner[s] = own;
				job_dflt[s] = preq;
				job_pri[s] = preq;
				job_wait[s] = '0;
				job_slice[s] = '0;
				job_run[s] = '0;
				add_waiting(0, s);
				nid = id_count;
			end
		end else if (mode == MODE_DEQ) begin
			if (run_valid && job_id[run_slot] == tgt) begin
				job_valid[run_slot] = 1'b0;
				run_valid = 1'b0;
				run_done = 1'b0;
				stopped = tgt;
			end else begin
				found = 1'b0;
				for (int l = Levels - 1; l >= 0 && !found; l--) begin
					for (pos = 0; pos < waitq[l].size(); pos++) begin
						if (job_id[waitq[l][pos]] == tgt) begin
							job_valid[waitq[l][pos]] = 1'b0;
							waitq[l].delete(pos);
							found = 1'b1;
							break;
						end
					end
				end
				if (!found) st = ST_NOTFOUND;
			end
		end else if (mode == MODE_STAT) begin
			if (run_valid) begin
				r = job_record(1'b1, 1'b1, run_slot);
				add_expected(r);
			end
			for (int l = Levels - 1; l >= 0; l--) begin
				foreach (waitq[l][i]) begin
					r = job_record(1'b1, 1'b1, waitq[l][i]);
					r.is_running = 1'b0;
					add_expected(r);
				end
			end
		end
		// Aging and promotion.
		if (run_valid) begin
			job_run[run_slot] = sat32(job_run[run_slot], tick_len);
			job_slice[run_slot] = sat20(job_slice[run_slot], tick_len);
		end
		for (int l = 0; l < Levels; l++) begin
			foreach (waitq[l][i]) begin
				s = waitq[l][i];
				job_wait[s] = sat20(job_wait[s], tick_len);
				if (job_wait[s] >= promote_lim && job_pri[s] < Levels) begin
					job_pri[s]++;
					job_wait[s] = '0;
				end
			end
		end
		// Move each waiting job to the queue of its level.
		for (int l = 0; l < Levels; l++) begin
			pos = 0;
			while (pos < waitq[l].size()) begin
				s = waitq[l][pos];
				t = lvl(job_pri[s]);
				if (t > l) begin
					waitq[l].delete(pos);
					add_waiting(t, s);
				end else begin
					pos++;
				end
			end
		end
		// Selection of the next job.
		highest = -1;
		lowest = 0;
		if (run_valid) begin
			if (job_slice[run_slot] < slice_len[lvl(job_pri[run_slot])])
				highest = job_pri[run_slot];
			lowest = lvl(job_pri[run_slot]);
		end
		for (int l = Levels - 1; l >= lowest; l--) begin
			best = -1;
			foreach (waitq[l][i]) begin
				if (int'(job_pri[waitq[l][i]]) > highest) begin
					best = i;
					highest = job_pri[waitq[l][i]];
				end
			end
			if (best >= 0) begin
				next_slot = waitq[l][best];
				waitq[l].delete(best);
				has_next = 1'b1;
				break;
			end
		end
		// Switch.
		if (run_valid && run_done) begin
			job_valid[run_slot] = 1'b0;
			run_valid = 1'b0;
			run_done = 1'b0;
		end
		if (!has_next && !run_valid) begin
			act = ACT_IDLE;
		end else if (has_next && !run_valid) begin
			run_slot = next_slot;
			run_valid = 1'b1;
			run_done = 1'b0;
			job_slice[next_slot] = '0;
			act = ACT_START;
		end else if (has_next) begin
			c = (job_pri[run_slot] > 0) ? job_pri[run_slot] - 1 : 0;
			if (c < job_dflt[run_slot]) c = job_dflt[run_slot];
			job_pri[run_slot] = 2'(c);
			job_wait[run_slot] = '0;
			add_waiting(lvl(2'(c)), run_slot);
			stopped = job_id[run_slot];
			run_slot = next_slot;
			run_done = 1'b0;
			job_slice[next_slot] = '0;
			job_wait[next_slot] = '0;
			act = ACT_SWITCH;
		end else begin
			act = ACT_KEEP;
		end
		r = job_record(1'b0, run_valid, run_slot);
		r.status = st;
		r.action = act;
		r.new_jid = nid;
		r.stopped_jid = stopped;
		r.last = 1'b1;
		add_expected(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endtask

	// Track configuration writes and input transactions; compare outputs.
	always @(posedge clk or negedge arst_n) begin
		result_t e, a;
		if (!arst_n) begin
			tick_len <= 16'd500;
			promote_lim <= 20'd10000;
			slice_len[0] <= 20'd5000;
			slice_len[1] <= 20'd2000;
			slice_len[2] <= 20'd1000;
			for (int i = 0; i < MaxJobs; i++) job_valid[i] = 1'b0;
			for (int l = 0; l < Levels; l++) waitq[l].delete();
			run_slot = 0;
			run_valid = 1'b0;
			run_done = 1'b0;
			id_count = '0;
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TICK: tick_len <= cfg_wdata[15:0];
					REG_PROMOTE: promote_lim <= cfg_wdata;
					REG_SLICE0: slice_len[0] <= cfg_wdata;
					REG_SLICE1: slice_len[1] <= cfg_wdata;
					REG_SLICE2: slice_len[2] <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) schedule_step(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				a = '0;
				a.kind = m_axis_tuser;
				a.last = m_axis_tlast;
				{a.stopped_jid, a.new_jid, a.action, a.status, a.is_running,
					a.cur_priority, a.wait_total, a.run_total, a.owner_id,
					a.jid} = m_axis_tdata[122:0];
				if (sched_results.size() == 0) begin
					$error("result with no expectation waiting: jid %0h", a.jid);
					errors++;
				end else begin
					e = sched_results.pop_front();
					check_field("kind", e.kind, a.kind);
					check_field("jid", e.jid, a.jid);
					check_field("owner_id", e.owner_id, a.owner_id);
					check_field("run_total", e.run_total, a.run_total);
					check_field("wait_total", e.wait_total, a.wait_total);
					check_field("cur_priority", e.cur_priority, a.cur_priority);
					check_field("is_running", e.is_running, a.is_running);
					check_field("status", e.status, a.status);
					check_field("action", e.action, a.action);
					check_field("new_jid", e.new_jid, a.new_jid);
					check_field("stopped_jid", e.stopped_jid, a.stopped_jid);
					check_field("last", e.last, a.last);
				end
			end
		end
	end
endmodule

@@ tb/tb_mlfq_job_scheduler.sv @@
// Testbench top for the feedback-queue job scheduler: clock, reset, stimulus
// and verdict. Depends on mjs_pkg, mlfq_job_scheduler and mlfq_checker.
`timescale 1ns / 1ps
module tb_mlfq_job_scheduler import mjs_pkg::*; ();
	logic         clk, arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [39:0]  s_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser, m_axis_tlast;
	logic         cfg_we;
	logic [2:0]   cfg_idx;
	logic [19:0]  cfg_wdata;
	int           pending, errors;
	int           tx_idle_pct, rx_idle_pct;
	int           enq_count;
	int           quiet_cycles;

	mlfq_job_scheduler u_top (.*);
	mlfq_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver readiness with random stalls.
	always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	// Watchdog: too long without any accepted transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_job_item(input logic [2:0] mode, input logic [1:0] pri,
		input logic [15:0] owner, input logic [15:0] target);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'd0, target, owner, pri, mode};
		if (mode == MODE_ENQ) enq_count++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Mostly well-formed command traffic with a share of odd items.
	task automatic random_traffic(input int n);
		int      pick;
		logic [15:0] tgt;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			tgt = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(enq_count + 1));
			if (pick < 32)
				send_job_item(MODE_ENQ, 2'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 55)
				send_job_item(MODE_TICK, 2'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 70)
				send_job_item(MODE_DEQ, 2'($urandom), 16'($urandom), tgt);
			else if (pick < 78)
				send_job_item(MODE_STAT, 2'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 93)
				send_job_item(MODE_DONE, 2'($urandom), 16'($urandom), 16'($urandom));
			else
				send_job_item(3'($urandom_range(5, 7)), 2'($urandom), 16'($urandom),
					16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		enq_count = 0;
		tx_idle_pct = 13;
		rx_idle_pct = 61;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration.
		send_job_item(MODE_TICK, 2'd0, 16'd0, 16'd0);
		send_job_item(MODE_DONE, 2'd0, 16'd0, 16'd0);
		send_job_item(MODE_ENQ, 2'd0, 16'h0000, 16'd0);
		send_job_item(MODE_ENQ, 2'd3, 16'hFFFF, 16'hFFFF);
		send_job_item(MODE_ENQ, 2'd1, 16'h1234, 16'd0);
		send_job_item(MODE_ENQ, 2'd2, 16'hABCD, 16'd0);
		send_job_item(MODE_STAT, 2'd0, 16'd0, 16'd0);
		send_job_item(MODE_DEQ, 2'd0, 16'd0, 16'hFFFF);
		send_job_item(MODE_DEQ, 2'd0, 16'd0, 16'd3);
		send_job_item(MODE_DEQ, 2'd0, 16'd0, 16'd2);
		send_job_item(MODE_DONE, 2'd0, 16'd0, 16'd0);
		send_job_item(MODE_TICK, 2'd0, 16'd0, 16'd0);
		send_job_item(3'd5, 2'd3, 16'hFFFF, 16'hFFFF);
		send_job_item(3'd6, 2'd0, 16'd0, 16'd0);
		send_job_item(3'd7, 2'd0, 16'd0, 16'd0);
		for (int i = 0; i < 8; i++) send_job_item(MODE_TICK, 2'd0, 16'd0, 16'd0);
		send_job_item(MODE_STAT, 2'd0, 16'd0, 16'd0);
		random_traffic(100);
		drain_results();

		// Extreme settings: largest tick, instant promotion, empty slices.
		write_reg(REG_TICK, 20'hFFFF);
		write_reg(REG_PROMOTE, 20'd0);
		write_reg(REG_SLICE0, 20'd0);
		write_reg(REG_SLICE1, 20'd0);
		write_reg(REG_SLICE2, 20'd0);
		tx_idle_pct = 61;
		rx_idle_pct = 13;
		random_traffic(60);
		drain_results();

		// Largest promotion limit and slices, so counters saturate.
		write_reg(REG_PROMOTE, 20'hFFFFF);
		write_reg(REG_SLICE0, 20'hFFFFF);
		write_reg(REG_SLICE1, 20'hFFFFF);
		write_reg(REG_SLICE2, 20'hFFFFF);
		random_traffic(50);
		drain_results();

		// No idling: zero tick, then moderate settings.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_TICK, 20'd0);
		random_traffic(30);
		drain_results();
		write_reg(REG_TICK, 20'd700);
		write_reg(REG_PROMOTE, 20'd3000);
		write_reg(REG_SLICE0, 20'd2800);
		write_reg(REG_SLICE1, 20'd1400);
		write_reg(REG_SLICE2, 20'd700);
		random_traffic(90);
		drain_results();

		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/mjs_pkg.sv
hdl/mjs_out_reg.sv
hdl/mlfq_job_scheduler.sv
tb/mlfq_checker.sv
tb/tb_mlfq_job_scheduler.sv
